// File: hw/rtl/jadc_pkg.sv
package jadc_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int REPORT_W    = 25;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int REL_LIMIT   = 127;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MID_POINT  = 3'd0,
    REG_FULL_TRAVEL = 3'd1,
    REG_DEAD_BAND  = 3'd2,
    REG_OUT_LOW    = 3'd3,
    REG_OUT_HIGH   = 3'd4,
    REG_GAIN_NUM   = 3'd5,
    REG_GAIN_DEN   = 3'd6,
    REG_MODE_FLAGS = 3'd7
  } cfg_reg_t;

  localparam logic [1:0] CURVE_SQRT   = 2'd1;
  localparam logic [1:0] CURVE_SQUARE = 2'd2;

  typedef struct packed {
    logic [15:0] mid;
    logic [15:0] travel;
    logic [15:0] dead;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] gnum;
    logic [15:0] gden;
    logic        enable;
    logic        invert;
    logic        relative;
    logic [1:0]  curve;
  } cfg_t;

  // Classified sample handed from front to back.
  typedef struct packed {
    logic        zero;
    logic        neg;
    logic [15:0] pushed;
    logic [15:0] span;
  } item_t;

endpackage

// File: hw/rtl/jadc_in_if.sv
interface jadc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [jadc_pkg::SAMPLE_W-1:0] sample_mv;
  modport source(output valid, output sample_mv, input ready);
  modport sink(input valid, input sample_mv, output ready);
endinterface

// File: hw/rtl/jadc_out_if.sv
interface jadc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [jadc_pkg::REPORT_W-1:0] report_value;
  modport source(output valid, output report_value, input ready);
  modport sink(input valid, input report_value, output ready);
endinterface

// File: hw/rtl/jadc_front.sv
module jadc_front (
  input  logic             clk,
  input  logic             rst_n,
  jadc_in_if.sink          in,
  input  jadc_pkg::cfg_t   cfg,
  output logic             item_valid,
  input  logic             item_ready,
  output jadc_pkg::item_t  item
);

  logic             f_v_r;
  jadc_pkg::item_t  f_item_r;
  jadc_pkg::item_t  f_item_nxt;
  logic signed [17:0] delta;
  logic [16:0]      amount;
  logic [16:0]      pushed_full;
  logic [15:0]      travel;
  logic [15:0]      span;

  always_comb begin
    delta       = 18'(in.sample_mv) - $signed({2'b00, cfg.mid});
    amount      = delta[17] ? 17'(-delta) : delta[16:0];
    travel      = (cfg.travel == 16'd0) ? 16'd1 : cfg.travel;
    span        = (travel > cfg.dead) ? (travel - cfg.dead) : 16'd1;
    pushed_full = amount - {1'b0, cfg.dead};
    f_item_nxt.zero   = !cfg.enable || (amount <= {1'b0, cfg.dead});
    f_item_nxt.neg    = delta[17];
    f_item_nxt.span   = span;
    f_item_nxt.pushed = (pushed_full > {1'b0, span}) ? span : pushed_full[15:0];
  end

  assign in.ready   = !f_v_r || item_ready;
  assign item_valid = f_v_r;
  assign item       = f_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (in.ready) begin
      f_v_r <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in.ready) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule

// File: hw/rtl/jadc_fifo.sv
module jadc_fifo #(
  parameter int DEPTH = jadc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  jadc_pkg::item_t wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output jadc_pkg::item_t rd_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  jadc_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            push;
  logic            pop;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// File: hw/rtl/jadc_back.sv
module jadc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  jadc_pkg::cfg_t  cfg,
  input  logic            item_valid,
  output logic            item_ready,
  input  jadc_pkg::item_t item,
  jadc_out_if.source      out
);

  localparam int NA = 16;
  localparam int NS = 16;
  localparam int NB = jadc_pkg::REPORT_W;

  logic en;
  logic out_v_r;
  logic signed [jadc_pkg::REPORT_W-1:0] out_val_r;

  assign en         = !out_v_r || out.ready;
  assign item_ready = en;

  // Normalize: pushed * 2^15 / span, one quotient bit per stage.
  logic        a_v    [NA+1];
  logic        a_zero [NA+1];
  logic        a_neg  [NA+1];
  logic [15:0] a_rem  [NA+1];
  logic [15:0] a_q    [NA+1];
  logic [15:0] a_span [NA+1];

  assign a_v[0]    = item_valid;
  assign a_zero[0] = item.zero;
  assign a_neg[0]  = item.neg;
  assign a_rem[0]  = item.pushed;
  assign a_q[0]    = '0;
  assign a_span[0] = item.span;

  for (genvar k = 0; k < NA; k++) begin : g_norm
    logic [16:0] r2;
    logic        ge;
    always_comb begin
      if (k == 0) begin
        r2 = {1'b0, a_rem[k]};
      end else begin
        r2 = {a_rem[k], 1'b0};
      end
      ge = r2 >= {1'b0, a_span[k]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_v[k+1] <= 1'b0;
      end else if (en) begin
        a_v[k+1] <= a_v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        a_zero[k+1] <= a_zero[k];
        a_neg[k+1]  <= a_neg[k];
        a_span[k+1] <= a_span[k];
        a_rem[k+1]  <= ge ? 16'(r2 - {1'b0, a_span[k]}) : r2[15:0];
        a_q[k+1]    <= {a_q[k][14:0], ge};
      end
    end
  end

  // Square root of norm * 2^15, one result bit per stage; square rides along.
  logic        s_v    [NS+1];
  logic        s_zero [NS+1];
  logic        s_neg  [NS+1];
  logic [15:0] s_n    [NS+1];
  logic [16:0] s_sq   [NS+1];
  logic [31:0] s_x    [NS+1];
  logic [31:0] s_res  [NS+1];
  logic [31:0] sq_full;

  assign sq_full   = a_q[NA] * a_q[NA];
  assign s_v[0]    = a_v[NA];
  assign s_zero[0] = a_zero[NA];
  assign s_neg[0]  = a_neg[NA];
  assign s_n[0]    = a_q[NA];
  assign s_sq[0]   = sq_full[31:15];
  assign s_x[0]    = {1'b0, a_q[NA], 15'b0};
  assign s_res[0]  = '0;

  for (genvar k = 0; k < NS; k++) begin : g_root
    localparam logic [31:0] PW = 32'd1 << (30 - 2 * k);
    logic [31:0] t;
    always_comb t = s_res[k] + PW;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_v[k+1] <= 1'b0;
      end else if (en) begin
        s_v[k+1] <= s_v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s_zero[k+1] <= s_zero[k];
        s_neg[k+1]  <= s_neg[k];
        s_n[k+1]    <= s_n[k];
        s_sq[k+1]   <= s_sq[k];
        if (s_x[k] >= t) begin
          s_x[k+1]   <= s_x[k] - t;
          s_res[k+1] <= (s_res[k] >> 1) + PW;
        end else begin
          s_x[k+1]   <= s_x[k];
          s_res[k+1] <= s_res[k] >> 1;
        end
      end
    end
  end

  // Curve select, span multiply, gain multiply.
  logic        c_v_r, c_zero_r, c_neg_r;
  logic [15:0] c_cur_r;
  logic [31:0] cur_nxt;
  logic        m_v_r, m_zero_r, m_neg_r;
  logic [24:0] m_prod_r;
  logic [8:0]  hi_eff;
  logic [8:0]  span9;
  logic        g_v_r, g_zero_r, g_neg_r;
  logic [24:0] g_prod_r;
  logic [8:0]  mag;
  logic [15:0] num;
  logic [15:0] den;

  always_comb begin
    case (cfg.curve)
      jadc_pkg::CURVE_SQRT:   cur_nxt = s_res[NS];
      jadc_pkg::CURVE_SQUARE: cur_nxt = {15'b0, s_sq[NS]};
      default:                cur_nxt = {16'b0, s_n[NS]};
    endcase
    hi_eff = ({1'b0, cfg.hi} > ({1'b0, cfg.lo} + 9'd1)) ? {1'b0, cfg.hi}
                                                       : ({1'b0, cfg.lo} + 9'd1);
    span9  = hi_eff - {1'b0, cfg.lo};
    mag    = {1'b0, cfg.lo} + 9'(m_prod_r[24:15]);
    num    = (cfg.gnum == 16'd0) ? 16'd1 : cfg.gnum;
    den    = (cfg.gden == 16'd0) ? 16'd1 : cfg.gden;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      m_v_r <= 1'b0;
      g_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= s_v[NS];
      m_v_r <= c_v_r;
      g_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_zero_r <= s_zero[NS];
      c_neg_r  <= s_neg[NS];
      c_cur_r  <= (cur_nxt > 32'd32768) ? 16'd32768 : cur_nxt[15:0];
      m_zero_r <= c_zero_r;
      m_neg_r  <= c_neg_r;
      m_prod_r <= span9 * c_cur_r;
      g_zero_r <= m_zero_r;
      g_neg_r  <= m_neg_r;
      g_prod_r <= mag * num;
    end
  end

  // Gain divide, one quotient bit per stage.
  logic        d_v    [NB+1];
  logic        d_zero [NB+1];
  logic        d_neg  [NB+1];
  logic [24:0] d_div  [NB+1];
  logic [15:0] d_rem  [NB+1];
  logic [24:0] d_q    [NB+1];

  assign d_v[0]    = g_v_r;
  assign d_zero[0] = g_zero_r;
  assign d_neg[0]  = g_neg_r;
  assign d_div[0]  = g_prod_r;
  assign d_rem[0]  = '0;
  assign d_q[0]    = '0;

  for (genvar k = 0; k < NB; k++) begin : g_gain
    logic [16:0] r2;
    logic        ge;
    always_comb begin
      r2 = {d_rem[k], d_div[k][24]};
      ge = r2 >= {1'b0, den};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_v[k+1] <= 1'b0;
      end else if (en) begin
        d_v[k+1] <= d_v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d_zero[k+1] <= d_zero[k];
        d_neg[k+1]  <= d_neg[k];
        d_div[k+1]  <= {d_div[k][23:0], 1'b0};
        d_rem[k+1]  <= ge ? 16'(r2 - {1'b0, den}) : r2[15:0];
        d_q[k+1]    <= {d_q[k][23:0], ge};
      end
    end
  end

  // Restore sign, apply inversion and relative clamp; force zero for dead-band or disabled items.
  logic signed [jadc_pkg::REPORT_W-1:0] res_nxt;
  logic signed [jadc_pkg::REPORT_W-1:0] mag_s;
  localparam logic signed [jadc_pkg::REPORT_W-1:0] LIM = jadc_pkg::REPORT_W'(jadc_pkg::REL_LIMIT);

  always_comb begin
    mag_s   = $signed(d_q[NB]);
    res_nxt = (d_neg[NB] ^ cfg.invert) ? -mag_s : mag_s;
    if (cfg.relative) begin
      if (res_nxt > LIM) begin
        res_nxt = LIM;
      end else if (res_nxt < -LIM) begin
        res_nxt = -LIM;
      end
    end
    if (d_zero[NB]) begin
      res_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= d_v[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val_r <= res_nxt;
    end
  end

  assign out.valid        = out_v_r;
  assign out.report_value = out_val_r;

endmodule

// File: hw/rtl/joystick_axis_deadzone_curve.sv
// Channel | Dir | Payload                         | Beat taken when
// in      | in  | sample_mv  16b signed (mV)      | in.valid && in.ready
// out     | out | report_value 25b signed         | out.valid && out.ready
// cfg     | in  | cfg_index 3b, cfg_data 16b      | cfg_we high
//
// One beat in and one beat out per cycle when both sides flow. From input to output
// a sample passes the front register, the queue, 16 normalize-divide, 16 square-root,
// three curve and multiply and 25 gain-divide stages, and the output register.
// Synchronous active-low reset clears all valid bits and loads register defaults.
// A stalled output freezes the back pipeline; the queue absorbs the front so
// input keeps flowing until the queue fills.
module joystick_axis_deadzone_curve #(
  parameter int QUEUE_DEPTH = jadc_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  jadc_in_if.sink                        in,
  jadc_out_if.source                     out,
  input  logic                           cfg_we,
  input  logic [jadc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jadc_pkg::CFG_W-1:0]     cfg_data
);

  jadc_pkg::cfg_t  cfg_r;
  logic            q_wr_valid;
  logic            q_wr_ready;
  jadc_pkg::item_t q_wr_item;
  logic            q_rd_valid;
  logic            q_rd_ready;
  jadc_pkg::item_t q_rd_item;

  // Configuration registers; user must write only with datapath empty; unchecked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mid      <= 16'd1650;
      cfg_r.travel   <= 16'd1650;
      cfg_r.dead     <= 16'd0;
      cfg_r.lo       <= 8'd0;
      cfg_r.hi       <= 8'd127;
      cfg_r.gnum     <= 16'd1;
      cfg_r.gden     <= 16'd1;
      cfg_r.enable   <= 1'b1;
      cfg_r.invert   <= 1'b0;
      cfg_r.relative <= 1'b0;
      cfg_r.curve    <= 2'd0;
    end else if (cfg_we) begin
      case (jadc_pkg::cfg_reg_t'(cfg_index))
        jadc_pkg::REG_MID_POINT:   cfg_r.mid    <= cfg_data;
        jadc_pkg::REG_FULL_TRAVEL: cfg_r.travel <= cfg_data;
        jadc_pkg::REG_DEAD_BAND:   cfg_r.dead   <= cfg_data;
        jadc_pkg::REG_OUT_LOW:     cfg_r.lo     <= cfg_data[7:0];
        jadc_pkg::REG_OUT_HIGH:    cfg_r.hi     <= cfg_data[7:0];
        jadc_pkg::REG_GAIN_NUM:    cfg_r.gnum   <= cfg_data;
        jadc_pkg::REG_GAIN_DEN:    cfg_r.gden   <= cfg_data;
        jadc_pkg::REG_MODE_FLAGS: begin
          cfg_r.enable   <= cfg_data[0];
          cfg_r.invert   <= cfg_data[1];
          cfg_r.relative <= cfg_data[2];
          cfg_r.curve    <= cfg_data[4:3];
        end
        default: ;
      endcase
    end
  end

  // Front: subtract rest point, split sign, classify dead band, clamp travel.
  jadc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in         (in),
    .cfg        (cfg_r),
    .item_valid (q_wr_valid),
    .item_ready (q_wr_ready),
    .item       (q_wr_item)
  );

  // Queue decouples front and back stalls.
  jadc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_item  (q_wr_item),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_item  (q_rd_item)
  );

  // Back: normalize, curve, map, gain, sign and clamp.
  jadc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (q_rd_valid),
    .item_ready (q_rd_ready),
    .item       (q_rd_item),
    .out        (out)
  );

`ifndef SYNTHESIS
  a_rel_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out.valid && cfg_r.relative |->
      (out.report_value <= 25'sd127) && (out.report_value >= -25'sd127))
    else $error("relative report exceeds limit");

  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out.valid && !cfg_r.enable |-> out.report_value == '0)
    else $error("disabled axis gave nonzero report");

  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr_valid && !q_wr_ready |=> q_wr_valid && $stable(q_wr_item))
    else $error("front dropped a stalled item");
`endif

endmodule

// File: bench/testbench.sv
module testbench;

  // Mode register bits and the curve field position.
  localparam int MODE_ENABLE   = 0;
  localparam int MODE_INVERT   = 1;
  localparam int MODE_RELATIVE = 2;
  localparam int MODE_CURVE_LO = 3;
  localparam logic [1:0] CURVE_LINEAR = 2'd0;
  localparam logic [1:0] CURVE_ALT_LINEAR = 2'd3;

  // Q15 unity and a drain wait that covers the pipeline depth plus margin.
  localparam longint unsigned Q15_ONE = 32768;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 130;
  localparam int RANDOM_PHASES = 14;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [15:0] mid;
    logic [15:0] travel;
    logic [15:0] dead;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] gnum;
    logic [15:0] gden;
    logic [4:0]  mode;
  } axis_setup_t;

  // One row of the directed table: a sample, and optionally a value read off by hand.
  typedef struct {
    logic signed [15:0] sample;
    bit                 typed;
    logic signed [24:0] report;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  jadc_pkg::cfg_reg_t cfg_index = jadc_pkg::REG_MID_POINT;
  logic [jadc_pkg::CFG_W-1:0] cfg_data = '0;

  jadc_in_if  in_ch();
  jadc_out_if out_ch();

  joystick_axis_deadzone_curve u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in        (in_ch),
    .out       (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the register file; follows every write we make.
  axis_setup_t axis_setup;

  // Reports still owed by the block, oldest first.
  logic signed [24:0] pending_reports[$];

  int mismatches = 0;
  int reports_seen = 0;
  int samples_sent = 0;
  int settings_used = 0;
  int cycle_count = 0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample_mv = '0;
    out_ch.ready = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic signed [24:0] got,
                                 input logic signed [24:0] want);
    mismatches++;
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
  endtask

  // Floor square root, one result bit at a time from the top.
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Work out the report for one sample under the current register values.
  function automatic logic signed [24:0] axis_report(input logic signed [15:0] sample);
    longint delta, amount, travel, span, pushed, norm, curved, top, mag, num, den;
    longint signed_mag;
    bit neg;
    logic [1:0] curve;
    if (!axis_setup.mode[MODE_ENABLE]) return '0;
    delta = longint'(sample) - longint'(axis_setup.mid);
    neg = delta < 0;
    amount = neg ? -delta : delta;
    // Drop anything inside the dead band.
    if (amount <= longint'(axis_setup.dead)) return '0;
    travel = axis_setup.travel == 0 ? 1 : longint'(axis_setup.travel);
    span = travel > longint'(axis_setup.dead) ? travel - longint'(axis_setup.dead) : 1;
    pushed = amount - longint'(axis_setup.dead);
    if (pushed > span) pushed = span;
    norm = (pushed * longint'(Q15_ONE)) / span;
    curve = axis_setup.mode[MODE_CURVE_LO +: 2];
    if (curve == jadc_pkg::CURVE_SQRT) curved = longint'(floor_root(norm * Q15_ONE));
    else if (curve == jadc_pkg::CURVE_SQUARE) curved = (norm * norm) / longint'(Q15_ONE);
    else curved = norm;
    if (curved > longint'(Q15_ONE)) curved = Q15_ONE;
    // Reversed or empty span: the top is pushed to one past the bottom.
    top = axis_setup.hi > axis_setup.lo + 1 ? axis_setup.hi : axis_setup.lo + 1;
    mag = axis_setup.lo + ((top - axis_setup.lo) * curved) / longint'(Q15_ONE);
    num = axis_setup.gnum == 0 ? 1 : longint'(axis_setup.gnum);
    den = axis_setup.gden == 0 ? 1 : longint'(axis_setup.gden);
    mag = (mag * num) / den;
    signed_mag = neg ? -mag : mag;
    if (axis_setup.mode[MODE_INVERT]) signed_mag = -signed_mag;
    if (axis_setup.mode[MODE_RELATIVE]) begin
      if (signed_mag > jadc_pkg::REL_LIMIT) signed_mag = jadc_pkg::REL_LIMIT;
      if (signed_mag < -jadc_pkg::REL_LIMIT) signed_mag = -jadc_pkg::REL_LIMIT;
    end
    return signed_mag[24:0];
  endfunction

  // Hold the config write enable across all eight registers, then drop it.
  task automatic apply_setup(input axis_setup_t s);
    logic [15:0] vals[8];
    vals = '{s.mid, s.travel, s.dead, 16'(s.lo), 16'(s.hi), s.gnum, s.gden, 16'(s.mode)};
    // Stop offering, then let in-flight beats clear; idle once nothing is owed.
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= jadc_pkg::cfg_reg_t'(i);
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    axis_setup = s;
    settings_used++;
    @(negedge clk);
  endtask

  function automatic int sender_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Offer one sample; the expected report is queued on the accepting edge.
  task automatic send_sample(input logic signed [15:0] sample, input bit typed,
                             input logic signed [24:0] typed_report, input bit gaps);
    int gap;
    logic signed [24:0] want;
    gap = gaps ? sender_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_mv <= sample;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = axis_report(sample);
    if (typed && want !== typed_report)
      $display("NOTE: predictor gives %0d for sample %0d, table says %0d",
               want, sample, typed_report);
    pending_reports.push_back(typed ? typed_report : want);
    samples_sent++;
    @(negedge clk);
  endtask

  // Mostly deflections around the rest point, the rest over the full input range.
  function automatic logic signed [15:0] pick_sample();
    longint reach, v;
    if ($urandom_range(0, 99) < 25) return 16'($urandom);
    reach = longint'(axis_setup.travel) + longint'(axis_setup.dead) + 64;
    if (reach > 70000) reach = 70000;
    v = longint'(axis_setup.mid) + longint'($urandom_range(0, 2 * reach)) - reach;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic logic [15:0] pick_wide();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 16));
      3: return 16'($urandom_range(100, 3000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic axis_setup_t random_setup();
    axis_setup_t s;
    s.mid = $urandom_range(0, 3) == 0 ? pick_wide() : 16'($urandom_range(0, 3300));
    s.travel = $urandom_range(0, 3) == 0 ? pick_wide() : 16'($urandom_range(1, 3000));
    s.dead = $urandom_range(0, 3) == 0 ? pick_wide() : 16'($urandom_range(0, 400));
    s.lo = 8'($urandom);
    s.hi = $urandom_range(0, 2) == 0 ? 8'($urandom) : 8'(s.lo + $urandom_range(1, 255 - s.lo));
    s.gnum = $urandom_range(0, 2) == 0 ? pick_wide() : 16'($urandom_range(1, 4));
    s.gden = $urandom_range(0, 2) == 0 ? pick_wide() : 16'($urandom_range(1, 4));
    s.mode = 5'($urandom);
    // Keep most phases enabled so the curve path gets exercised.
    if ($urandom_range(0, 5) != 0) s.mode[MODE_ENABLE] = 1'b1;
    return s;
  endfunction

  function automatic axis_setup_t setup_of(input logic [15:0] mid, input logic [15:0] travel,
                                           input logic [15:0] dead, input logic [7:0] lo,
                                           input logic [7:0] hi, input logic [15:0] gnum,
                                           input logic [15:0] gden, input logic [4:0] mode);
    axis_setup_t s;
    s = '{mid, travel, dead, lo, hi, gnum, gden, mode};
    return s;
  endfunction

  // Rest point, band edges, full travel and the input extremes for this setup.
  task automatic probe_edges();
    longint m, pts[9];
    m = axis_setup.mid;
    pts = '{m, m + axis_setup.dead, m + axis_setup.dead + 1, m - axis_setup.dead - 1,
            m + axis_setup.travel, m - axis_setup.travel, m + 1, 32767, -32768};
    foreach (pts[i]) begin
      if (pts[i] > 32767) pts[i] = 32767;
      if (pts[i] < -32768) pts[i] = -32768;
      send_sample(16'(pts[i]), 1'b0, '0, 1'b0);
    end
  endtask

  // Sample the result channel on the rising edge; compare against the oldest owed report.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      reports_seen <= reports_seen + 1;
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected report_value beat", out_ch.report_value, '0);
      end else begin
        logic signed [24:0] want;
        want = pending_reports.pop_front();
        if (out_ch.report_value !== want)
          report_mismatch("report_value", out_ch.report_value, want);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d reports owed", cycle_count,
               pending_reports.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls, clean stretches, and one long hold-off on request.
  initial begin
    int stall;
    int clean;
    @(negedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_ch.ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        // Run with no back-pressure for a while.
        clean = $urandom_range(20, 120);
        out_ch.ready <= 1'b1;
        repeat (clean) @(negedge clk);
      end else begin
        stall = $urandom_range(0, 99) < 60 ? 0 :
                ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(4, 30));
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  sample_row_t reset_rows[$];

  initial begin
    // Defaults after reset: rest 1650 mV, travel 1650 mV, no dead band, 0..127, unity gain.
    reset_rows = '{
      '{16'sd1650,   1'b1, 25'sd0},
      '{16'sd3300,   1'b1, 25'sd127},
      '{16'sd0,      1'b1, -25'sd127},
      '{16'sd32767,  1'b1, 25'sd127},
      '{-16'sd32768, 1'b1, -25'sd127},
      '{16'sd1651,   1'b0, 25'sd0},
      '{16'sd1649,   1'b0, 25'sd0},
      '{16'sd2475,   1'b0, 25'sd0},
      '{16'sd825,    1'b0, 25'sd0},
      '{16'sd3299,   1'b0, 25'sd0},
      '{-16'sd1,     1'b0, 25'sd0},
      '{16'sh5555,   1'b0, 25'sd0},
      '{16'shAAAA,   1'b0, 25'sd0}
    };
    axis_setup = setup_of(16'd1650, 16'd1650, 16'd0, 8'd0, 8'd127, 16'd1, 16'd1, 5'd1);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (reset_rows[i])
      send_sample(reset_rows[i].sample, reset_rows[i].typed, reset_rows[i].report, 1'b0);

    // Directed settings: disabled, each curve incl. code 3, invert and relative clamp,
    // zero travel, dead band at or past travel, reversed span, zero and max gains.
    apply_setup(setup_of(16'd1650, 16'd1650, 16'd100, 8'd0, 8'd127, 16'd1, 16'd1, 5'd0));
    probe_edges();
    apply_setup(setup_of(16'd1650, 16'd1650, 16'd100, 8'd10, 8'd200, 16'd1, 16'd1,
                         {jadc_pkg::CURVE_SQRT, 3'b011}));
    probe_edges();
    apply_setup(setup_of(16'd1650, 16'd1650, 16'd100, 8'd10, 8'd200, 16'd3, 16'd1,
                         {jadc_pkg::CURVE_SQUARE, 3'b101}));
    probe_edges();
    apply_setup(setup_of(16'd0, 16'd0, 16'd0, 8'd255, 8'd0, 16'd0, 16'd0,
                         {CURVE_ALT_LINEAR, 3'b001}));
    probe_edges();
    apply_setup(setup_of(16'hFFFF, 16'd500, 16'd800, 8'd255, 8'd255, 16'hFFFF, 16'd1,
                         {CURVE_LINEAR, 3'b011}));
    probe_edges();
    apply_setup(setup_of(16'd0, 16'hFFFF, 16'hFFFF, 8'd0, 8'd255, 16'd1, 16'hFFFF,
                         {jadc_pkg::CURVE_SQRT, 3'b111}));
    probe_edges();

    // Random phases; the first one leans on the receiver's long hold-off.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_setup(random_setup());
      if (p == 0) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_sample(pick_sample(), 1'b0, '0, p != 0);
    end
    in_ch.valid <= 1'b0;

    while (pending_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d samples and %0d reports over %0d register settings",
             samples_sent, reports_seen, settings_used);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
